@@ hdl/erwp_pkg.sv @@
// Package for the SPARC ELF32 relocation word patcher.
// Holds the relocation type codes, the per-type tables, decode and stage payload types.
// No dependencies.
`timescale 1ns / 1ps

package erwp_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 8;
    localparam int unsigned TBL_N  = 24;

    localparam logic [KIND_W-1:0] KIND_NONE       = 8'd0;
    localparam logic [KIND_W-1:0] KIND_COPY       = 8'd19;
    localparam logic [KIND_W-1:0] KIND_JUMP_SLOT  = 8'd21;
    localparam logic [KIND_W-1:0] KIND_RELATIVE   = 8'd22;
    localparam logic [KIND_W-1:0] KIND_TABLE_LAST = 8'd23;
    localparam logic [KIND_W-1:0] KIND_TLS_FIRST  = 8'd56;
    localparam logic [KIND_W-1:0] KIND_LE_HIX22   = 8'd72;
    localparam logic [KIND_W-1:0] KIND_LE_LOX10   = 8'd73;
    localparam logic [KIND_W-1:0] KIND_DTPMOD32   = 8'd74;
    localparam logic [KIND_W-1:0] KIND_DTPOFF32   = 8'd76;
    localparam logic [KIND_W-1:0] KIND_LAST       = 8'd79;

    localparam logic [WORD_W-1:0] LOX10_MASK = 32'h0000_03ff;
    localparam logic [WORD_W-1:0] LOX10_BITS = 32'h0000_1c00;

    // bit n set: type n adds the symbol / subtracts the place
    localparam logic [TBL_N-1:0] KIND_SYM_BITS = 24'b1001_0011_0001_1111_1111_1110;
    localparam logic [TBL_N-1:0] KIND_PC_BITS  = 24'b0000_0111_0000_0001_1111_0000;

    localparam logic [3:0] KIND_SHIFT [TBL_N] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd2,
        4'd2, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd10,
        4'd0, 4'd10, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam logic [WORD_W-1:0] KIND_MASK [TBL_N] = '{
        32'h0000_0000,
        32'h0000_00ff, 32'h0000_ffff, 32'hffff_ffff,
        32'h0000_00ff, 32'h0000_ffff, 32'hffff_ffff,
        32'h3fff_ffff, 32'h003f_ffff,
        32'h003f_ffff, 32'h003f_ffff,
        32'h0000_1fff, 32'h0000_03ff,
        32'h0000_03ff, 32'h0000_1fff, 32'h003f_ffff,
        32'h0000_03ff, 32'h003f_ffff,
        32'h3fff_ffff, 32'h0000_0000,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_ffff
    };

    typedef enum logic [2:0] {
        OP_KEEP,
        OP_FAIL,
        OP_TABLE,
        OP_RELATIVE,
        OP_DTPOFF,
        OP_HIX22,
        OP_LOX10
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              use_sym;
        logic              pc_rel;
        logic [3:0]        shift;
        logic [WORD_W-1:0] mask;
    } ctrl_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic [WORD_W-1:0] place;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] rel_sum;
        logic [WORD_W-1:0] old_word;
    } s1_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic [WORD_W-1:0] place;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] rel_word;
        logic [WORD_W-1:0] old_word;
    } s2_t;

    function automatic ctrl_t decode_kind(input logic [KIND_W-1:0] kind);
        ctrl_t      c;
        logic [4:0] idx;
        idx       = kind[4:0];
        c.op      = OP_FAIL;
        c.use_sym = 1'b0;
        c.pc_rel  = 1'b0;
        c.shift   = 4'd0;
        c.mask    = '0;
        if (kind == KIND_NONE || kind == KIND_COPY || kind == KIND_JUMP_SLOT ||
            kind == KIND_DTPMOD32) begin
            c.op = OP_KEEP;
        end else if (kind > KIND_LAST) begin
            c.op = OP_FAIL;
        end else if (kind >= KIND_TLS_FIRST) begin
            c.use_sym = 1'b1;
            if (kind == KIND_DTPOFF32) begin
                c.op = OP_DTPOFF;
            end else if (kind == KIND_LE_HIX22) begin
                c.op = OP_HIX22;
            end else if (kind == KIND_LE_LOX10) begin
                c.op = OP_LOX10;
            end else begin
                c.op = OP_FAIL;
            end
        end else if (kind > KIND_TABLE_LAST) begin
            c.op = OP_FAIL;
        end else if (kind == KIND_RELATIVE) begin
            c.op = OP_RELATIVE;
        end else begin
            c.op      = OP_TABLE;
            c.use_sym = KIND_SYM_BITS[idx];
            c.pc_rel  = KIND_PC_BITS[idx];
            c.shift   = KIND_SHIFT[idx];
            c.mask    = KIND_MASK[idx];
        end
        return c;
    endfunction

endpackage

@@ hdl/elf_relocation_word_patcher.sv @@
// Top level of the SPARC ELF32 RELA relocation word patcher.
// Depends on erwp_pkg, erwp_front, erwp_mid and erwp_back.
// One register per stage; an accepted transaction leaves from the stage 3 register.
// Throughput: one transaction per cycle while m_ready is high; each stage holds one
// item and refills as its successor advances, so a stalled output backs up stage by
// stage without loss.
// Reset: synchronous active-low aresetn clears the three stage valid bits only.
`timescale 1ns / 1ps

module elf_relocation_word_patcher (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [erwp_pkg::KIND_W-1:0]  s_kind,
    input  logic [erwp_pkg::WORD_W-1:0]  s_addend,
    input  logic [erwp_pkg::WORD_W-1:0]  s_symbol_value,
    input  logic [erwp_pkg::WORD_W-1:0]  s_section_base,
    input  logic [erwp_pkg::WORD_W-1:0]  s_offset_in_section,
    input  logic [erwp_pkg::WORD_W-1:0]  s_old_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [erwp_pkg::WORD_W-1:0]  m_target_address,
    output logic [erwp_pkg::WORD_W-1:0]  m_new_word,
    output logic                         m_write_enable,
    output logic                         m_status
);
    import erwp_pkg::*;

    // stage 1 -> 2
    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    // stage 2 -> 3
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    // Stage 1: decode the type into an op class plus table flags, form the place
    // address, addend (+ symbol) and the RELATIVE base + addend.
    erwp_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_valid),
        .in_ready          (s_ready),
        .kind              (s_kind),
        .addend            (s_addend),
        .symbol_value      (s_symbol_value),
        .section_base      (s_section_base),
        .offset_in_section (s_offset_in_section),
        .old_word          (s_old_word),
        .out_valid         (s1_valid),
        .out_ready         (s1_ready),
        .out_data          (s1_data)
    );

    // Stage 2: subtract the place for PC-relative types; old word + base + addend.
    erwp_mid u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: shift/mask/merge, TLS forms, unchanged and failing types; this
    // register is the output register of the result channel.
    erwp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s2_valid),
        .in_ready       (s2_ready),
        .in_data        (s2_data),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .target_address (m_target_address),
        .new_word       (m_new_word),
        .write_enable   (m_write_enable),
        .status         (m_status)
    );

    // A failing type never requests a write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_write_enable)
        else $error("failing relocation asserted write_enable");

    // Input back-pressure only when every stage is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid && s2_valid && m_valid))
        else $error("s_ready low with a free pipeline stage");

    // An accepted transaction lands in stage 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_valid)
        else $error("accepted transaction lost at stage 1");

    // A stalled stage 2 item is kept until stage 3 takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid && !s2_ready |=> s2_valid)
        else $error("stalled stage 2 item dropped");

endmodule

@@ hdl/erwp_front.sv @@
// First pipeline stage: type decode, place address and the first adds.
// Depends on erwp_pkg.
`timescale 1ns / 1ps

module erwp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [erwp_pkg::KIND_W-1:0]  kind,
    input  logic [erwp_pkg::WORD_W-1:0]  addend,
    input  logic [erwp_pkg::WORD_W-1:0]  symbol_value,
    input  logic [erwp_pkg::WORD_W-1:0]  section_base,
    input  logic [erwp_pkg::WORD_W-1:0]  offset_in_section,
    input  logic [erwp_pkg::WORD_W-1:0]  old_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output erwp_pkg::s1_t                out_data
);
    import erwp_pkg::*;

    logic  valid_reg;
    s1_t   data_reg;
    s1_t   data_next;
    ctrl_t ctrl;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        ctrl               = decode_kind(kind);
        data_next.ctrl     = ctrl;
        data_next.place    = section_base + offset_in_section;
        data_next.sum      = addend + (ctrl.use_sym ? symbol_value : '0);
        data_next.rel_sum  = section_base + addend;
        data_next.old_word = old_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/erwp_mid.sv @@
// Second pipeline stage: PC-relative subtract and the RELATIVE sum.
// Depends on erwp_pkg.
`timescale 1ns / 1ps

module erwp_mid (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  erwp_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output erwp_pkg::s2_t out_data
);
    import erwp_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.ctrl     = in_data.ctrl;
        data_next.place    = in_data.place;
        data_next.value    = in_data.ctrl.pc_rel ? (in_data.sum - in_data.place) : in_data.sum;
        data_next.rel_word = in_data.old_word + in_data.rel_sum;
        data_next.old_word = in_data.old_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/erwp_back.sv @@
// Third pipeline stage: shift, mask, merge and result select into the output register.
// Depends on erwp_pkg.
`timescale 1ns / 1ps

module erwp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  erwp_pkg::s2_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [erwp_pkg::WORD_W-1:0] target_address,
    output logic [erwp_pkg::WORD_W-1:0] new_word,
    output logic                        write_enable,
    output logic                        status
);
    import erwp_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] addr_reg;
    logic [WORD_W-1:0] word_reg;
    logic              we_reg;
    logic              status_reg;
    logic [WORD_W-1:0] word_next;
    logic              we_next;
    logic              status_next;
    logic [WORD_W-1:0] field;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        field       = (in_data.value >> in_data.ctrl.shift) & in_data.ctrl.mask;
        word_next   = in_data.old_word;
        we_next     = 1'b1;
        status_next = 1'b0;
        case (in_data.ctrl.op)
            OP_KEEP: begin
                we_next = 1'b0;
            end
            OP_TABLE: begin
                word_next = (in_data.old_word & ~in_data.ctrl.mask) | field;
            end
            OP_RELATIVE: begin
                word_next = in_data.rel_word;
            end
            OP_DTPOFF: begin
                word_next = in_data.value;
            end
            OP_HIX22: begin
                word_next = in_data.old_word | (~in_data.value >> 10);
            end
            OP_LOX10: begin
                word_next = in_data.old_word | (in_data.value & LOX10_MASK) | LOX10_BITS;
            end
            default: begin
                we_next     = 1'b0;
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            addr_reg   <= in_data.place;
            word_reg   <= word_next;
            we_reg     <= we_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = valid_reg;
    assign target_address = addr_reg;
    assign new_word       = word_reg;
    assign write_enable   = we_reg;
    assign status         = status_reg;

endmodule

@@ verif/tb.sv @@
// Testbench for elf_relocation_word_patcher: directed and random relocation records,
// checked against an in-bench predictor of the patched word, write flag and status.
// Depends on erwp_pkg for the relocation type codes and the TLS low-part constants.
`timescale 1ns / 1ps

module tb;
    import erwp_pkg::*;

    // Thread-pointer offset type has no named constant in the package; it must fail.
    localparam logic [KIND_W-1:0] KIND_TP_OFFSET = 8'd78;
    localparam int unsigned       REPORT_MAX     = 10;
    localparam int unsigned       DRAIN_CYCLES   = 10;   // slack after the last expected result

    // Per-type tables for the table-driven relocations (types 0..23):
    // field mask, right shift, whether the symbol is added, whether the place is subtracted.
    localparam logic [WORD_W-1:0] FIELD_MASK [24] = '{
        32'h0000_0000,
        32'h0000_00ff, 32'h0000_ffff, 32'hffff_ffff,
        32'h0000_00ff, 32'h0000_ffff, 32'hffff_ffff,
        32'h3fff_ffff, 32'h003f_ffff,
        32'h003f_ffff, 32'h003f_ffff,
        32'h0000_1fff, 32'h0000_03ff,
        32'h0000_03ff, 32'h0000_1fff, 32'h003f_ffff,
        32'h0000_03ff, 32'h003f_ffff,
        32'h3fff_ffff, 32'h0000_0000,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_ffff
    };
    localparam logic [4:0] FIELD_SHIFT [24] = '{
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd2,
        5'd2, 5'd10, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd10,
        5'd0, 5'd10, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };
    localparam bit TAKES_SYMBOL [24] = '{
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
    };
    localparam bit SUBTRACTS_PLACE [24] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] addend;
        logic [WORD_W-1:0] symbol_value;
        logic [WORD_W-1:0] section_base;
        logic [WORD_W-1:0] offset_in_section;
        logic [WORD_W-1:0] old_word;
    } reloc_t;

    typedef struct {
        logic [WORD_W-1:0] target_address;
        logic [WORD_W-1:0] new_word;
        logic              write_enable;
        logic              status;
    } patch_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind;
    logic [WORD_W-1:0] s_addend;
    logic [WORD_W-1:0] s_symbol_value;
    logic [WORD_W-1:0] s_section_base;
    logic [WORD_W-1:0] s_offset_in_section;
    logic [WORD_W-1:0] s_old_word;
    logic              m_valid;
    logic              m_ready;
    logic [WORD_W-1:0] m_target_address;
    logic [WORD_W-1:0] m_new_word;
    logic              m_write_enable;
    logic              m_status;

    patch_t      expected_patches [$];   // predictions in acceptance order
    int unsigned mismatch_count;
    bit          no_idle;                // when set, neither side inserts gaps

    elf_relocation_word_patcher u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_addend           (s_addend),
        .s_symbol_value     (s_symbol_value),
        .s_section_base     (s_section_base),
        .s_offset_in_section(s_offset_in_section),
        .s_old_word         (s_old_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_target_address   (m_target_address),
        .m_new_word         (m_new_word),
        .m_write_enable     (m_write_enable),
        .m_status           (m_status)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Predicted result of one relocation record. All sums wrap at 32 bits.
    function automatic patch_t predict_patch(input reloc_t r);
        patch_t            p;
        logic [WORD_W-1:0] place;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] mask;
        logic [4:0]        idx;
        place            = r.section_base + r.offset_in_section;
        value            = r.symbol_value + r.addend;
        idx              = r.kind[4:0];
        p.target_address = place;
        p.new_word       = r.old_word;
        p.write_enable   = 1'b0;
        p.status         = 1'b0;
        if (r.kind == KIND_NONE || r.kind == KIND_COPY || r.kind == KIND_JUMP_SLOT ||
            r.kind == KIND_DTPMOD32) begin
            // success, word left alone
        end else if (r.kind > KIND_LAST) begin
            p.status = 1'b1;
        end else if (r.kind >= KIND_TLS_FIRST) begin
            p.write_enable = 1'b1;
            case (r.kind)
                KIND_DTPOFF32: p.new_word = value;
                KIND_LE_HIX22: p.new_word = r.old_word | (~value >> 10);
                KIND_LE_LOX10: p.new_word = r.old_word | (value & LOX10_MASK) | LOX10_BITS;
                default: begin
                    p.write_enable = 1'b0;
                    p.status       = 1'b1;
                end
            endcase
        end else if (r.kind > KIND_TABLE_LAST) begin
            // past the end of the per-type table
            p.status = 1'b1;
        end else if (r.kind == KIND_RELATIVE) begin
            p.new_word     = r.old_word + r.section_base + r.addend;
            p.write_enable = 1'b1;
        end else begin
            mask  = FIELD_MASK[idx];
            value = r.addend;
            if (TAKES_SYMBOL[idx]) begin
                value = value + r.symbol_value;
            end
            if (SUBTRACTS_PLACE[idx]) begin
                value = value - place;
            end
            value          = (value >> FIELD_SHIFT[idx]) & mask;
            p.new_word     = (r.old_word & ~mask) | value;
            p.write_enable = 1'b1;
        end
        return p;
    endfunction

    function automatic int unsigned idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Word patterns that hit field extremes; sel cycles through them.
    function automatic logic [WORD_W-1:0] directed_word(input int unsigned sel);
        case (sel % 4)
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Weighted toward types that do work; the rest draws from wider, mostly failing ranges.
    function automatic reloc_t random_reloc();
        reloc_t r;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                r.kind = KIND_W'($urandom_range(0, KIND_TABLE_LAST));
            10: r.kind = KIND_LE_HIX22;
            11: r.kind = KIND_LE_LOX10;
            12: r.kind = KIND_DTPOFF32;
            13: r.kind = KIND_DTPMOD32;
            14, 15, 16: r.kind = KIND_W'($urandom_range(KIND_TABLE_LAST + 1, KIND_LAST));
            default: r.kind = KIND_W'($urandom_range(0, 255));
        endcase
        r.addend            = random_word();
        r.symbol_value      = random_word();
        r.section_base      = random_word();
        r.offset_in_section = random_word();
        r.old_word          = random_word();
        return r;
    endfunction

    // Sends one relocation record. Entered and left at a falling edge; valid stays
    // high when the next record follows with no gap.
    task automatic send_reloc(input reloc_t r);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_kind              = r.kind;
        s_addend            = r.addend;
        s_symbol_value      = r.symbol_value;
        s_section_base      = r.section_base;
        s_offset_in_section = r.offset_in_section;
        s_old_word          = r.old_word;
        s_valid             = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Every type in the table range, including NONE, COPY, the jump slot, RELATIVE and
    // UA_32, with each field rotating through all-zero, all-one, sign-bit and random words.
    task automatic test_table_kinds();
        reloc_t r;
        for (int k = 0; k <= KIND_TABLE_LAST; k++) begin
            r.kind              = KIND_W'(k);
            r.addend            = directed_word(k);
            r.symbol_value      = directed_word(k + 1);
            r.section_base      = directed_word(k + 2);
            r.offset_in_section = directed_word(k + 3);
            r.old_word          = directed_word(k + 5);
            send_reloc(r);
        end
    endtask

    // TLS handling and the failing ranges, one record each.
    task automatic test_tls_and_invalid_kinds();
        logic [KIND_W-1:0] kinds [9];
        reloc_t            r;
        kinds = '{KIND_DTPMOD32, KIND_DTPOFF32, KIND_LE_HIX22, KIND_LE_LOX10,
                  KIND_TP_OFFSET, KIND_TLS_FIRST, KIND_TABLE_LAST + 8'd1,
                  KIND_LAST + 8'd1, '1};
        foreach (kinds[i]) begin
            r.kind              = kinds[i];
            r.addend            = directed_word(i + 1);
            r.symbol_value      = directed_word(i + 3);
            r.section_base      = directed_word(i);
            r.offset_in_section = directed_word(i + 2);
            r.old_word          = directed_word(i + 1);
            send_reloc(r);
        end
    endtask

    // Random records; idling is switched off for stretches now and then.
    task automatic test_random_stream(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_reloc(random_reloc());
        end
        no_idle = 1'b0;
    endtask

    // Back-to-back burst, then the sender holds off until the pipe is empty,
    // then a second burst starting from an idle pipe.
    task automatic test_drain_pause();
        no_idle = 1'b1;
        repeat (40) send_reloc(random_reloc());
        s_valid = 1'b0;
        while (expected_patches.size() != 0) @(negedge aclk);
        repeat (40) send_reloc(random_reloc());
        no_idle = 1'b0;
    endtask

    // Result side: a random m_ready gap before each transaction, none when no_idle is set.
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Scoreboard. The prediction is queued first so that even a same-cycle result
    // would find its expectation.
    always @(posedge aclk) begin
        reloc_t r;
        patch_t exp_patch;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                r.kind              = s_kind;
                r.addend            = s_addend;
                r.symbol_value      = s_symbol_value;
                r.section_base      = s_section_base;
                r.offset_in_section = s_offset_in_section;
                r.old_word          = s_old_word;
                expected_patches.push_back(predict_patch(r));
            end
            if (m_valid && m_ready) begin
                if (expected_patches.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("ERROR: result transaction with nothing expected, addr %h",
                                 m_target_address);
                    end
                end else begin
                    exp_patch = expected_patches.pop_front();
                    if (m_target_address !== exp_patch.target_address ||
                        m_new_word !== exp_patch.new_word ||
                        m_write_enable !== exp_patch.write_enable ||
                        m_status !== exp_patch.status) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("ERROR: addr exp %h got %h, word exp %h got %h",
                                     exp_patch.target_address, m_target_address,
                                     exp_patch.new_word, m_new_word);
                            $display("       we exp %b got %b, status exp %b got %b",
                                     exp_patch.write_enable, m_write_enable,
                                     exp_patch.status, m_status);
                        end
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin
        mismatch_count      = 0;
        no_idle             = 1'b0;
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_kind              = '0;
        s_addend            = '0;
        s_symbol_value      = '0;
        s_section_base      = '0;
        s_offset_in_section = '0;
        s_old_word          = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_table_kinds();
        test_tls_and_invalid_kinds();
        test_random_stream(600);
        test_drain_pause();
        test_random_stream(550);

        s_valid = 1'b0;
        while (expected_patches.size() != 0) @(posedge aclk);
        // catch any stray result transactions
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_patches.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: worst case is about 1300 records, far below this timeout.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/erwp_pkg.sv
hdl/erwp_front.sv
hdl/erwp_mid.sv
hdl/erwp_back.sv
hdl/elf_relocation_word_patcher.sv
verif/tb.sv
